@@ hw/rtl/imu_pkg.sv @@
// Shared widths, codes and reset values for the IMU bias calibration block.
package imu_pkg;

    // Collection takes a gyro sample every SAMPLE_PERIOD_MS-th tick.
    localparam int SAMPLE_PERIOD_MS = 10;
    localparam int PDIV_W = $clog2(SAMPLE_PERIOD_MS + 1);

    // Field and state widths.
    localparam int RAW_W      = 16;
    localparam int RATE_W     = 23;
    localparam int ACC_W      = 25;
    localparam int OFF_W      = 21;
    localparam int GAIN_W     = 16;
    localparam int TIME_W     = 16;
    localparam int SUM_W      = 30;
    localparam int CNT_W      = 13;
    localparam int DVD_W      = 36;
    localparam int STEP_W     = $clog2(DVD_W);
    localparam int PROD_W     = 42;
    localparam int ACC_SHIFT  = 14;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 21;
    localparam int AXES       = 3;

    localparam logic [1:0]       LAST_AXIS = 2'(AXES - 1);
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Reset values of the configuration registers.
    localparam logic [TIME_W-1:0]       SETTLE_RST  = 16'd5000;
    localparam logic [TIME_W-1:0]       COLLECT_RST = 16'd2500;
    localparam logic signed [OFF_W-1:0] OFF_X_RST   = 21'sd23605;
    localparam logic signed [OFF_W-1:0] OFF_Y_RST   = -21'sd6748;
    localparam logic signed [OFF_W-1:0] OFF_Z_RST   = 21'sd14031;
    localparam logic [GAIN_W-1:0]       GAIN_X_RST  = 16'd16508;
    localparam logic [GAIN_W-1:0]       GAIN_Y_RST  = 16'd16353;
    localparam logic [GAIN_W-1:0]       GAIN_Z_RST  = 16'd16283;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETTLE_MS  = 8'd0,
        REG_COLLECT_MS = 8'd1,
        REG_OFFSET_X   = 8'd2,
        REG_OFFSET_Y   = 8'd3,
        REG_OFFSET_Z   = 8'd4,
        REG_GAIN_X     = 8'd5,
        REG_GAIN_Y     = 8'd6,
        REG_GAIN_Z     = 8'd7
    } cfg_reg_t;

    // Calibration phase as reported on the result word.
    typedef enum logic [1:0] {
        PH_SETTLE  = 2'd0,
        PH_COLLECT = 2'd1,
        PH_CAL     = 2'd2
    } phase_t;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ hw/rtl/imu_div.sv @@
// Iterative signed divider, one quotient bit per cycle, for the bias average.
module imu_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [imu_pkg::DVD_W-1:0]     dividend,
    input  logic        [imu_pkg::CNT_W-1:0]     divisor,
    output imu_pkg::div_stat_t                   stat,
    output logic signed [imu_pkg::RATE_W-1:0]    quotient
);
    import imu_pkg::*;

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                neg_reg, neg_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [CNT_W-1:0]    dsr_reg, dsr_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;

    logic [CNT_W:0]      rem_sh;
    logic [CNT_W:0]      rem_sub;
    logic                ge;
    logic [DVD_W-1:0]    abs_dvd;
    logic [RATE_W-1:0]   mag;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};
    assign ge      = (rem_sh >= {1'b0, dsr_reg});
    assign abs_dvd = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            run_next  = 1'b1;
            step_next = '0;
            neg_next  = dividend[DVD_W-1];
            dvd_next  = abs_dvd;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (run_reg) begin
            dvd_next  = {dvd_reg[DVD_W-2:0], ge};
            rem_next  = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DVD_W - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        neg_reg  <= neg_next;
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        rem_reg  <= rem_next;
    end

    // The average magnitude always fits the rate width; restore the sign.
    assign mag       = dvd_reg[RATE_W-1:0];
    assign quotient  = neg_reg ? -$signed(mag) : $signed(mag);
    assign stat.busy = run_reg;
    assign stat.done = done_reg;

endmodule

@@ hw/rtl/imu_corr.sv @@
// Accel correction unit: offset, registered gain multiply, floor shift, saturate.
module imu_corr (
    input  logic                               aclk,
    input  logic                               load,
    input  logic signed [imu_pkg::RAW_W-1:0]   raw_accel,
    input  logic signed [imu_pkg::OFF_W-1:0]   offset,
    input  logic        [imu_pkg::GAIN_W-1:0]  gain,
    output logic signed [imu_pkg::ACC_W-1:0]   result
);
    import imu_pkg::*;

    localparam logic signed [PROD_W-1:0] ACC_HI = PROD_W'((2 ** (ACC_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] ACC_LO = -PROD_W'(2 ** (ACC_W - 1));

    logic signed [ACC_W-1:0]  raw_ext;
    logic signed [ACC_W-1:0]  diff;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] shifted;

    // raw * 244 as 256 - 8 - 4, then remove the offset in micro-g.
    assign raw_ext   = ACC_W'(raw_accel);
    assign diff      = (raw_ext <<< 8) - (raw_ext <<< 3) - (raw_ext <<< 2) - ACC_W'(offset);
    assign prod_next = diff * $signed({1'b0, gain});

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

    // Arithmetic shift rounds toward minus infinity.
    assign shifted = prod_reg >>> ACC_SHIFT;

    always_comb begin
        if (shifted > ACC_HI) begin
            result = ACC_HI[ACC_W-1:0];
        end else if (shifted < ACC_LO) begin
            result = ACC_LO[ACC_W-1:0];
        end else begin
            result = shifted[ACC_W-1:0];
        end
    end

endmodule

@@ hw/rtl/imu_bias_calibration_and_correction.sv @@
// Top level: tick sequencer, calibration state, shared divider and correction unit.
//
//  channel  dir  ports                       word
//  s_       in   s_tvalid/s_tready/s_tdata   six raw IMU words, one per ms tick
//  m_       out  m_tvalid/m_tready/m_tdata   corrected rates and accels, phase in m_tuser
//  cfg_     in   cfg_wr_en/index/wdata       register write, no handshake
//
// An ordinary tick runs from acceptance through one state update, a load and a
// saturate step in the correction unit for each axis, and a final step that loads
// the result register. The tick that ends the collection window also runs the
// shared 36-step divider once per axis before the correction. Reset is
// synchronous and active low and restores the registers to their defaults. A new
// word is taken while the last result still waits; the sequencer stalls only
// before loading a result over one not yet taken.
module imu_bias_calibration_and_correction (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // raw_gyro_x, raw_gyro_y, raw_gyro_z, raw_accel_x, raw_accel_y, raw_accel_z
    input  logic [95:0]                         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z
    output logic [143:0]                        m_tdata,
    // phase
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_wr_en,
    input  logic [imu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [imu_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import imu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CORR,
        ST_SAT,
        ST_DONE
    } state_t;

    localparam logic signed [RATE_W-1:0] RATE_HI = {1'b0, {(RATE_W - 1){1'b1}}};
    localparam logic signed [RATE_W-1:0] RATE_LO = {1'b1, {(RATE_W - 1){1'b0}}};

    // Configuration registers.
    logic [TIME_W-1:0]       settle_reg;
    logic [TIME_W-1:0]       collect_reg;
    logic signed [OFF_W-1:0] off_reg [AXES];
    logic [GAIN_W-1:0]       gain_reg [AXES];

    // Sequencer and calibration state.
    state_t                  state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    logic [TIME_W-1:0]       ticks_reg, ticks_next;
    logic [PDIV_W-1:0]       pdiv_reg, pdiv_next;
    logic signed [SUM_W-1:0] sum_reg [AXES];
    logic signed [SUM_W-1:0] sum_next [AXES];
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [RATE_W-1:0] bias_reg [AXES];
    logic signed [RATE_W-1:0] bias_next [AXES];
    logic [1:0]              axis_reg, axis_next;

    // Captured input word and per-axis results.
    logic signed [RAW_W-1:0] gyro_reg [AXES];
    logic signed [RAW_W-1:0] acc_raw_reg [AXES];
    logic signed [RATE_W-1:0] rate_res_reg [AXES];
    logic signed [RATE_W-1:0] rate_res_next [AXES];
    logic signed [ACC_W-1:0] acc_res_reg [AXES];
    logic signed [ACC_W-1:0] acc_res_next [AXES];

    // Output register.
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [143:0]            m_tdata_reg, m_tdata_next;
    logic [1:0]              m_tuser_reg, m_tuser_next;

    // Phase update terms.
    logic                    enter;
    logic                    in_coll;
    logic                    finish;
    logic                    take;
    logic [TIME_W-1:0]       t1;
    logic [PDIV_W-1:0]       d1;

    // Shared units.
    logic                    div_start;
    logic signed [DVD_W-1:0] div_dvd;
    logic signed [DVD_W-1:0] sum_ext;
    div_stat_t               div_stat;
    logic signed [RATE_W-1:0] div_q;
    logic                    corr_load;
    logic signed [ACC_W-1:0] corr_res;

    // Gyro rate of the current axis.
    logic signed [RATE_W:0]  g_ext;
    logic signed [RATE_W:0]  rate_diff;
    logic signed [RATE_W-1:0] rate_sat;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg  <= SETTLE_RST;
            collect_reg <= COLLECT_RST;
            off_reg[0]  <= OFF_X_RST;
            off_reg[1]  <= OFF_Y_RST;
            off_reg[2]  <= OFF_Z_RST;
            gain_reg[0] <= GAIN_X_RST;
            gain_reg[1] <= GAIN_Y_RST;
            gain_reg[2] <= GAIN_Z_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SETTLE_MS:  settle_reg  <= cfg_wdata[TIME_W-1:0];
                REG_COLLECT_MS: collect_reg <= cfg_wdata[TIME_W-1:0];
                REG_OFFSET_X:   off_reg[0]  <= $signed(cfg_wdata[OFF_W-1:0]);
                REG_OFFSET_Y:   off_reg[1]  <= $signed(cfg_wdata[OFF_W-1:0]);
                REG_OFFSET_Z:   off_reg[2]  <= $signed(cfg_wdata[OFF_W-1:0]);
                REG_GAIN_X:     gain_reg[0] <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_Y:     gain_reg[1] <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_Z:     gain_reg[2] <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Settling ends on this tick when the wait is used up; the same tick then
    // counts as a collecting tick.
    assign enter   = (phase_reg == PH_SETTLE) && (ticks_reg >= settle_reg);
    assign in_coll = (phase_reg == PH_COLLECT) || enter;
    assign t1      = enter ? '0 : ticks_reg;
    assign d1      = enter ? '0 : pdiv_reg;
    assign finish  = in_coll && (t1 >= collect_reg);
    assign take    = in_coll && !finish && (t1 != '0) && (d1 == '0) &&
                     (count_reg != COUNT_MAX);

    // Dividend is sum * 70, built as 64 + 4 + 2.
    assign sum_ext = DVD_W'(sum_reg[axis_reg]);
    assign div_dvd = (sum_ext <<< 6) + (sum_ext <<< 2) + (sum_ext <<< 1);

    imu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (count_reg),
        .stat     (div_stat),
        .quotient (div_q)
    );

    imu_corr u_corr (
        .aclk      (aclk),
        .load      (corr_load),
        .raw_accel (acc_raw_reg[axis_reg]),
        .offset    (off_reg[axis_reg]),
        .gain      (gain_reg[axis_reg]),
        .result    (corr_res)
    );

    // Gyro in millidegrees per second minus bias, saturated.
    assign g_ext     = (RATE_W + 1)'(gyro_reg[axis_reg]);
    assign rate_diff = (g_ext <<< 6) + (g_ext <<< 2) + (g_ext <<< 1) -
                       (RATE_W + 1)'(bias_reg[axis_reg]);

    always_comb begin
        if (rate_diff[RATE_W] != rate_diff[RATE_W-1]) begin
            rate_sat = rate_diff[RATE_W] ? RATE_LO : RATE_HI;
        end else begin
            rate_sat = rate_diff[RATE_W-1:0];
        end
    end

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        ticks_next    = ticks_reg;
        pdiv_next     = pdiv_reg;
        count_next    = count_reg;
        axis_next     = axis_reg;
        sum_next      = sum_reg;
        bias_next     = bias_reg;
        rate_res_next = rate_res_reg;
        acc_res_next  = acc_res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        div_start     = 1'b0;
        corr_load     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                axis_next  = '0;
                state_next = ST_CORR;
                if ((phase_reg == PH_SETTLE) && !enter) begin
                    ticks_next = ticks_reg + 1'b1;
                end
                if (in_coll) begin
                    if (finish) begin
                        phase_next = PH_CAL;
                        // With no samples the biases stay at zero.
                        if (count_reg != '0) begin
                            state_next = ST_DIV_START;
                        end
                    end else begin
                        phase_next = PH_COLLECT;
                        ticks_next = t1 + 1'b1;
                        pdiv_next  = (d1 == PDIV_W'(SAMPLE_PERIOD_MS - 1)) ? '0 : d1 + 1'b1;
                        if (take) begin
                            for (int i = 0; i < AXES; i++) begin
                                sum_next[i] = sum_reg[i] + SUM_W'(gyro_reg[i]);
                            end
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    bias_next[axis_reg] = div_q;
                    if (axis_reg == LAST_AXIS) begin
                        axis_next  = '0;
                        state_next = ST_CORR;
                    end else begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_CORR: begin
                corr_load  = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT: begin
                rate_res_next[axis_reg] = rate_sat;
                acc_res_next[axis_reg]  = corr_res;
                if (axis_reg == LAST_AXIS) begin
                    state_next = ST_DONE;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_CORR;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {acc_res_reg[2], acc_res_reg[1], acc_res_reg[0],
                                     rate_res_reg[2], rate_res_reg[1], rate_res_reg[0]};
                    m_tuser_next  = phase_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_SETTLE;
            ticks_reg    <= '0;
            pdiv_reg     <= '0;
            count_reg    <= '0;
            axis_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                sum_reg[i]  <= '0;
                bias_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            ticks_reg    <= ticks_next;
            pdiv_reg     <= pdiv_next;
            count_reg    <= count_next;
            axis_reg     <= axis_next;
            m_tvalid_reg <= m_tvalid_next;
            sum_reg      <= sum_next;
            bias_reg     <= bias_next;
        end
        rate_res_reg <= rate_res_next;
        acc_res_reg  <= acc_res_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        // Capture the input word when it is accepted.
        if (s_tvalid && s_tready) begin
            for (int i = 0; i < AXES; i++) begin
                gyro_reg[i]    <= $signed(s_tdata[i*RAW_W +: RAW_W]);
                acc_raw_reg[i] <= $signed(s_tdata[(i + AXES)*RAW_W +: RAW_W]);
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    // Once calibrated, the block stays calibrated until reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CAL) |=> (phase_reg == PH_CAL))
        else $error("calibrated phase was left");

    // Biases stay zero until the calibrated phase is reached.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_CAL) |->
        (bias_reg[0] == '0 && bias_reg[1] == '0 && bias_reg[2] == '0))
        else $error("bias changed before calibration");

    // The sample count moves only on the state update of a tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_UPDATE) |=> $stable(count_reg))
        else $error("sample count changed outside the update step");

    // The divider runs only while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> (state_reg == ST_DIV_WAIT))
        else $error("divider busy outside the divide wait");

    // A new result word is loaded only from the final sequencer step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word loaded outside the final step");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the IMU bias calibration and accel correction block.
module testbench;
    import imu_pkg::*;

    localparam int ITEMS = 1650;
    localparam int SETTLE_STRETCH = 320;
    localparam int QUIET_FROM = 900;
    localparam int QUIET_TO = 1150;
    localparam int IDLE_PCT = 14;
    localparam int DRAIN_CYCLES = 150;
    localparam logic [CFG_DATA_W-1:0] GAIN_ONE = 21'd16384;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd200;

    // One input word, raw_gyro_x in the lowest bits.
    typedef struct packed {
        logic signed [RAW_W-1:0] raw_accel_z, raw_accel_y, raw_accel_x;
        logic signed [RAW_W-1:0] raw_gyro_z, raw_gyro_y, raw_gyro_x;
    } imu_word_t;

    // One result word with the phase on top, as seen on {m_tuser, m_tdata}.
    typedef struct packed {
        phase_t phase;
        logic signed [ACC_W-1:0] accel_z, accel_y, accel_x;
        logic signed [RATE_W-1:0] rate_z, rate_y, rate_x;
    } calib_out_t;

    // A row of the opening sequence: a register write or a tick.
    typedef struct packed {
        logic is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic typed;
        imu_word_t word;
        calib_out_t want;
    } opening_row_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [95:0] s_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Mirror of the block's registers and calibration state.
    logic [TIME_W-1:0] settle_ms, collect_ms;
    logic signed [OFF_W-1:0] accel_off[3];
    logic [GAIN_W-1:0] accel_gain[3];
    phase_t cal_phase;
    logic [TIME_W-1:0] phase_ticks;
    longint gyro_sums[3];
    int sample_count;
    longint gyro_bias[3];

    calib_out_t corrected_words[$];
    opening_row_t opening[$];
    calib_out_t want_word, got_word;
    int gyro_base[3];
    int ticks_sent = 0;
    int mismatches = 0;
    bit no_idle = 1'b0;

    imu_bias_calibration_and_correction uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic imu_word_t raw6(int gx, int gy, int gz, int ax, int ay, int az);
        imu_word_t w;
        w.raw_gyro_x = 16'(gx);
        w.raw_gyro_y = 16'(gy);
        w.raw_gyro_z = 16'(gz);
        w.raw_accel_x = 16'(ax);
        w.raw_accel_y = 16'(ay);
        w.raw_accel_z = 16'(az);
        return w;
    endfunction

    function automatic calib_out_t out7(int rx, int ry, int rz, int ax, int ay, int az,
                                        phase_t ph);
        calib_out_t r;
        r.rate_x = 23'(rx);
        r.rate_y = 23'(ry);
        r.rate_z = 23'(rz);
        r.accel_x = 25'(ax);
        r.accel_y = 25'(ay);
        r.accel_z = 25'(az);
        r.phase = ph;
        return r;
    endfunction

    function automatic opening_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                             logic [CFG_DATA_W-1:0] val);
        opening_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic opening_row_t tick_row(imu_word_t w);
        opening_row_t r;
        r = '0;
        r.word = w;
        return r;
    endfunction

    function automatic opening_row_t known_row(imu_word_t w, calib_out_t want);
        opening_row_t r;
        r = '0;
        r.word = w;
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    // Register update as the block sees it: values are cut to the register's width.
    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_SETTLE_MS:  settle_ms = val[TIME_W-1:0];
            REG_COLLECT_MS: collect_ms = val[TIME_W-1:0];
            REG_OFFSET_X:   accel_off[0] = val;
            REG_OFFSET_Y:   accel_off[1] = val;
            REG_OFFSET_Z:   accel_off[2] = val;
            REG_GAIN_X:     accel_gain[0] = val[GAIN_W-1:0];
            REG_GAIN_Y:     accel_gain[1] = val[GAIN_W-1:0];
            REG_GAIN_Z:     accel_gain[2] = val[GAIN_W-1:0];
            default: ;
        endcase
    endfunction

    // Advances the calibration state by one tick and returns the corrected word.
    function automatic calib_out_t calibrate_and_correct(imu_word_t w);
        longint gyro[3];
        longint accel[3];
        longint rate_v[3];
        longint acc_v[3];
        calib_out_t r;
        gyro[0] = w.raw_gyro_x;
        gyro[1] = w.raw_gyro_y;
        gyro[2] = w.raw_gyro_z;
        accel[0] = w.raw_accel_x;
        accel[1] = w.raw_accel_y;
        accel[2] = w.raw_accel_z;

        // Settling hands over to collecting on the same tick.
        if (cal_phase == PH_SETTLE) begin
            if (phase_ticks >= settle_ms) begin
                cal_phase = PH_COLLECT;
                phase_ticks = '0;
            end else begin
                phase_ticks++;
            end
        end
        if (cal_phase == PH_COLLECT) begin
            if (phase_ticks >= collect_ms) begin
                for (int i = 0; i < 3; i++)
                    gyro_bias[i] = (sample_count == 0) ? 0
                                 : (gyro_sums[i] * 70) / longint'(sample_count);
                cal_phase = PH_CAL;
            end else begin
                if (phase_ticks != 0 && phase_ticks % SAMPLE_PERIOD_MS == 0 &&
                    sample_count < int'(COUNT_MAX)) begin
                    for (int i = 0; i < 3; i++)
                        gyro_sums[i] += gyro[i];
                    sample_count++;
                end
                phase_ticks = phase_ticks + 1'b1;
            end
        end

        // Rate and accel correction with saturation; the shift rounds down.
        for (int i = 0; i < 3; i++) begin
            rate_v[i] = gyro[i] * 70 - gyro_bias[i];
            if (rate_v[i] > 4194303) rate_v[i] = 4194303;
            if (rate_v[i] < -4194304) rate_v[i] = -4194304;
            acc_v[i] = ((accel[i] * 244 - longint'(accel_off[i])) *
                        longint'({1'b0, accel_gain[i]})) >>> ACC_SHIFT;
            if (acc_v[i] > 16777215) acc_v[i] = 16777215;
            if (acc_v[i] < -16777216) acc_v[i] = -16777216;
        end
        r.rate_x = 23'(rate_v[0]);
        r.rate_y = 23'(rate_v[1]);
        r.rate_z = 23'(rate_v[2]);
        r.accel_x = 25'(acc_v[0]);
        r.accel_y = 25'(acc_v[1]);
        r.accel_z = 25'(acc_v[2]);
        r.phase = cal_phase;
        return r;
    endfunction

    // Random raw value with the extremes and the values next to zero favored.
    function automatic logic [RAW_W-1:0] raw_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // Gyro reading scattered around a steady rest value.
    function automatic logic [RAW_W-1:0] near_rest(int base);
        int v;
        v = base + int'($urandom_range(0, 127)) - 64;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] reg_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 21'h1FFFFF;
            2: return 21'h0FFFFF;
            3: return 21'h100000;
            4: return GAIN_ONE;
            5: return 21'h00FFFF;
            default: return 21'($urandom);
        endcase
    endfunction

    // Offers one word to the block, with random gaps before it when allowed.
    task automatic put_tick(imu_word_t w, logic typed, calib_out_t want);
        calib_out_t fresh;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        do @(posedge aclk); while (!s_tready);
        fresh = calibrate_and_correct(w);
        corrected_words.push_back(typed ? want : fresh);
        ticks_sent++;
        no_idle = (ticks_sent >= QUIET_FROM && ticks_sent < QUIET_TO);
        @(negedge aclk);
    endtask

    // Register writes happen only once every outstanding word has come back.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (corrected_words.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        apply_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Unless any_reg is set, the window timing registers are left alone.
    task automatic write_random_reg(bit any_reg);
        logic [CFG_IDX_W-1:0] idx;
        idx = CFG_IDX_W'($urandom_range(any_reg ? 0 : 2, int'(REG_GAIN_Z) + 1));
        if (idx > REG_GAIN_Z)
            idx = CFG_IDX_W'($urandom_range(int'(REG_GAIN_Z) + 1, 255));
        write_reg(idx, reg_value());
    endtask

    task automatic run_segment(int n);
        imu_word_t w;
        repeat (n) begin
            if (cal_phase == PH_COLLECT && $urandom_range(0, 9) != 0) begin
                w.raw_gyro_x = near_rest(gyro_base[0]);
                w.raw_gyro_y = near_rest(gyro_base[1]);
                w.raw_gyro_z = near_rest(gyro_base[2]);
            end else begin
                w.raw_gyro_x = raw_sample();
                w.raw_gyro_y = raw_sample();
                w.raw_gyro_z = raw_sample();
            end
            w.raw_accel_x = raw_sample();
            w.raw_accel_y = raw_sample();
            w.raw_accel_z = raw_sample();
            put_tick(w, 1'b0, '0);
        end
    endtask

    // Result side: random stalls, none during the quiet stretch.
    always @(negedge aclk)
        m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Each accepted result word is matched against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (corrected_words.size() == 0) begin
                $error("result word with no prediction waiting");
                mismatches++;
            end else begin
                want_word = corrected_words.pop_front();
                got_word = calib_out_t'({m_tuser, m_tdata});
                check_field("rate_x", want_word.rate_x, got_word.rate_x);
                check_field("rate_y", want_word.rate_y, got_word.rate_y);
                check_field("rate_z", want_word.rate_z, got_word.rate_z);
                check_field("accel_x", want_word.accel_x, got_word.accel_x);
                check_field("accel_y", want_word.accel_y, got_word.accel_y);
                check_field("accel_z", want_word.accel_z, got_word.accel_z);
                check_field("phase", want_word.phase, got_word.phase);
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        settle_ms = SETTLE_RST;
        collect_ms = COLLECT_RST;
        accel_off = '{OFF_X_RST, OFF_Y_RST, OFF_Z_RST};
        accel_gain = '{GAIN_X_RST, GAIN_Y_RST, GAIN_Z_RST};
        cal_phase = PH_SETTLE;
        phase_ticks = '0;
        gyro_sums = '{0, 0, 0};
        sample_count = 0;
        gyro_bias = '{0, 0, 0};

        // Opening sequence: reset values, then unit gain so results read off directly,
        // then gain and offset extremes, an unused index and an oversized write.
        opening = '{
            tick_row(raw6(100, -200, 300, 4096, -4096, 16384)),
            tick_row(raw6(32767, -32768, 0, 32767, -32768, -1)),
            tick_row(raw6(0, 0, 0, 0, 0, 0)),
            cfg_row(REG_OFFSET_X, '0),
            cfg_row(REG_OFFSET_Y, '0),
            cfg_row(REG_OFFSET_Z, '0),
            cfg_row(REG_GAIN_X, GAIN_ONE),
            cfg_row(REG_GAIN_Y, GAIN_ONE),
            cfg_row(REG_GAIN_Z, GAIN_ONE),
            known_row(raw6(32767, -32768, 0, 32767, -32768, 0),
                      out7(2293690, -2293760, 0, 7995148, -7995392, 0, PH_SETTLE)),
            known_row(raw6(-1, 1, -32768, -1, 1, 32767),
                      out7(-70, 70, -2293760, -244, 244, 7995148, PH_SETTLE)),
            cfg_row(REG_GAIN_X, 21'h00FFFF),
            cfg_row(REG_GAIN_Y, 21'h00FFFF),
            cfg_row(REG_GAIN_Z, 21'h00FFFF),
            known_row(raw6(0, 0, 32767, 32767, -32768, 1),
                      out7(0, 0, 2293690, 16777215, -16777216, 975, PH_SETTLE)),
            known_row(raw6(0, 0, 0, -1, 0, -32768),
                      out7(0, 0, 0, -976, 0, -16777216, PH_SETTLE)),
            cfg_row(REG_OFFSET_X, 21'h100000),
            cfg_row(REG_OFFSET_Y, 21'h0FFFFF),
            cfg_row(REG_GAIN_X, '0),
            cfg_row(REG_GAIN_Y, GAIN_ONE),
            known_row(raw6(0, 0, 0, 32767, -32768, 0),
                      out7(0, 0, 0, 0, -9043967, 0, PH_SETTLE)),
            cfg_row(REG_UNUSED, 21'h1FFFFF),
            cfg_row(REG_SETTLE_MS, 21'h1FFFFF),
            tick_row(raw6(1234, -4321, 77, -12345, 23456, -7))
        };

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (opening[i]) begin
            if (opening[i].is_cfg) begin
                write_reg(opening[i].reg_idx, opening[i].reg_val);
            end else begin
                put_tick(opening[i].word, opening[i].typed, opening[i].want);
            end
        end

        // Settling: settle time stays far out of reach while accel settings move.
        while (ticks_sent < SETTLE_STRETCH) begin
            run_segment($urandom_range(15, 60));
            write_random_reg(1'b0);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SETTLE_MS, 21'($urandom_range(40000, 65535)));
        end

        // Pick a rest rate per axis, often near full scale so that the
        // corrected rate can saturate later.
        foreach (gyro_base[i]) begin
            if ($urandom_range(0, 1) == 0)
                gyro_base[i] = int'($urandom_range(0, 65535)) - 32768;
            else if ($urandom_range(0, 1) == 0)
                gyro_base[i] = int'($urandom_range(28000, 32767));
            else
                gyro_base[i] = -int'($urandom_range(28000, 32768));
        end
        if ($urandom_range(0, 5) == 0)
            write_reg(REG_COLLECT_MS, 21'($urandom_range(0, 10)));
        else
            write_reg(REG_COLLECT_MS, 21'($urandom_range(300, 600)));
        write_reg(REG_SETTLE_MS, '0);

        // Collecting until the biases are latched.
        while (cal_phase != PH_CAL) begin
            run_segment($urandom_range(15, 60));
            write_random_reg(1'b0);
        end

        // Calibrated: timing writes must no longer change anything.
        while (ticks_sent < ITEMS) begin
            run_segment($urandom_range(15, 60));
            write_random_reg(1'b1);
        end

        s_tvalid <= 1'b0;
        while (corrected_words.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/imu_pkg.sv
hw/rtl/imu_div.sv
hw/rtl/imu_corr.sv
hw/rtl/imu_bias_calibration_and_correction.sv
tb/testbench.sv
